FILE: rtl/core/kvt_pkg.sv
// Shared types and codes for the key/value table.
package kvt_pkg;

	// Operation codes carried on the command port
	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_UPDATE = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_REMOVE = 2'd3
	} cmd_t;

	// Completion codes carried on the status port
	typedef enum logic [1:0] {
		STAT_DONE    = 2'd0,
		STAT_ABSENT  = 2'd1,
		STAT_PRESENT = 2'd2,
		STAT_FULL    = 2'd3
	} status_t;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_WRITE = 5'b10000
	} state_t;

	localparam int unsigned KEY_BITS = 32;

	// One key memory word: valid flag and stored key
	typedef struct packed {
		logic                valid;
		logic [KEY_BITS-1:0] key;
	} key_entry_t;

	// Write strobes toward the slot memories
	typedef struct packed {
		logic key_we;
		logic val_we;
	} wr_ctl_t;

	// Result fields other than the value word
	typedef struct packed {
		logic    found;
		status_t status;
	} res_t;

endpackage

FILE: rtl/core/key_value_table.sv
// Key/value table top level: slot memories, scan sequencer and output register.
//
// Usage: each input word (command, key, value_in) is one operation: insert,
// update, lookup or remove. Both channels use valid/ready; a word moves when
// valid and ready are high at a rising edge of clk. Every input word yields
// exactly one output word (found, value_out, status).
// Operation: an accepted word is scanned over all DEPTH slots, one slot read per
// cycle from the key and value memories, then its write-back and output word
// are given together. One word is worked on at a time: no new word is taken
// until the last one has been written back.
// Reset: arst_n low empties the table. After release the block sweeps all
// DEPTH slots to clear their valid flags, one slot per cycle, and holds
// in_ready low until the sweep is done.
// Stall: the output word sits in a register; the next input word is accepted
// and scanned while it waits. If the output register is still full when the
// next result is ready, the write-back and result hold until out_ready.
module key_value_table #(
	parameter int unsigned DEPTH      = 64,
	parameter int unsigned VALUE_BITS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic signed [31:0] key,
	input  logic [63:0]        value_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               found,
	output logic [63:0]        value_out,
	output logic [1:0]         status
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	kvt_pkg::wr_ctl_t      wr_ctl;
	logic [AW-1:0]         wr_addr;
	kvt_pkg::key_entry_t   wr_key;
	logic [VALUE_BITS-1:0] wr_val;
	logic [AW-1:0]         rd_addr;
	kvt_pkg::key_entry_t   rd_key;
	logic [VALUE_BITS-1:0] rd_val;
	logic                  res_ready;
	logic                  res_valid;
	kvt_pkg::res_t         res;
	logic [VALUE_BITS-1:0] res_val;
	logic                  out_valid_q;
	logic                  found_q;
	logic [63:0]           value_q;
	logic [1:0]            status_q;

	kvt_store #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS),
		.AW         (AW)
	) u_store (
		.clk     (clk),
		.wr_ctl  (wr_ctl),
		.wr_addr (wr_addr),
		.wr_key  (wr_key),
		.wr_val  (wr_val),
		.rd_addr (rd_addr),
		.rd_key  (rd_key),
		.rd_val  (rd_val)
	);

	kvt_scan #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS),
		.AW         (AW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.key       (key),
		.value_in  (value_in),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res       (res),
		.res_val   (res_val),
		.wr_ctl    (wr_ctl),
		.wr_addr   (wr_addr),
		.wr_key    (wr_key),
		.wr_val    (wr_val),
		.rd_addr   (rd_addr),
		.rd_key    (rd_key),
		.rd_val    (rd_val)
	);

	assign res_ready = !out_valid_q || out_ready;

	// Hold the output word until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			found_q  <= res.found;
			value_q  <= 64'(res_val);
			status_q <= res.status;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign value_out = value_q;
	assign status    = status_q;

endmodule

FILE: rtl/core/kvt_store.sv
// Slot memories: key/valid words and value words, one read and one write port each.
module kvt_store #(
	parameter int unsigned DEPTH      = 64,
	parameter int unsigned VALUE_BITS = 64,
	parameter int unsigned AW         = 6
) (
	input  logic                   clk,
	input  kvt_pkg::wr_ctl_t       wr_ctl,
	input  logic [AW-1:0]          wr_addr,
	input  kvt_pkg::key_entry_t    wr_key,
	input  logic [VALUE_BITS-1:0]  wr_val,
	input  logic [AW-1:0]          rd_addr,
	output kvt_pkg::key_entry_t    rd_key,
	output logic [VALUE_BITS-1:0]  rd_val
);

	kvt_pkg::key_entry_t   key_mem [DEPTH];
	logic [VALUE_BITS-1:0] val_mem [DEPTH];

	// Write the key/valid memory and register its read word
	always_ff @(posedge clk) begin
		if (wr_ctl.key_we) begin
			key_mem[wr_addr] <= wr_key;
		end
		rd_key <= key_mem[rd_addr];
	end

	// Write the value memory and register its read word
	always_ff @(posedge clk) begin
		if (wr_ctl.val_we) begin
			val_mem[wr_addr] <= wr_val;
		end
		rd_val <= val_mem[rd_addr];
	end

endmodule

FILE: rtl/core/kvt_scan.sv
// Scan sequencer: clears the table, scans all slots per word and writes back the result.
module kvt_scan #(
	parameter int unsigned DEPTH      = 64,
	parameter int unsigned VALUE_BITS = 64,
	parameter int unsigned AW         = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input word
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             command,
	input  logic [31:0]            key,
	input  logic [63:0]            value_in,
	// Result toward the output register
	input  logic                   res_ready,
	output logic                   res_valid,
	output kvt_pkg::res_t          res,
	output logic [VALUE_BITS-1:0]  res_val,
	// Slot memory ports
	output kvt_pkg::wr_ctl_t       wr_ctl,
	output logic [AW-1:0]          wr_addr,
	output kvt_pkg::key_entry_t    wr_key,
	output logic [VALUE_BITS-1:0]  wr_val,
	output logic [AW-1:0]          rd_addr,
	input  kvt_pkg::key_entry_t    rd_key,
	input  logic [VALUE_BITS-1:0]  rd_val
);

	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	kvt_pkg::state_t       state_q;
	logic [AW-1:0]         addr_q;
	logic                  pend_s1;
	logic [AW-1:0]         idx_s1;
	kvt_pkg::cmd_t         cmd_q;
	logic [31:0]           key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic                  hit_q;
	logic [AW-1:0]         hit_idx_q;
	logic [VALUE_BITS-1:0] hit_val_q;
	logic                  free_q;
	logic [AW-1:0]         free_idx_q;
	logic                  accept;
	logic                  fire;
	logic                  match;

	assign in_ready  = (state_q == kvt_pkg::ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign res_valid = (state_q == kvt_pkg::ST_WRITE);
	assign fire      = res_valid && res_ready;
	assign rd_addr   = addr_q;
	assign match     = rd_key.valid && (rd_key.key == key_q);

	// Advance the sequencer and the slot counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kvt_pkg::ST_CLEAR;
			addr_q  <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= (state_q == kvt_pkg::ST_SCAN);
			unique case (state_q)
				kvt_pkg::ST_CLEAR: begin
					addr_q <= addr_q + AW'(1);
					if (addr_q == LAST) begin
						state_q <= kvt_pkg::ST_IDLE;
					end
				end
				kvt_pkg::ST_IDLE: begin
					addr_q <= '0;
					if (accept) begin
						state_q <= kvt_pkg::ST_SCAN;
					end
				end
				kvt_pkg::ST_SCAN: begin
					addr_q <= addr_q + AW'(1);
					if (addr_q == LAST) begin
						state_q <= kvt_pkg::ST_DRAIN;
					end
				end
				kvt_pkg::ST_DRAIN: begin
					state_q <= kvt_pkg::ST_WRITE;
				end
				kvt_pkg::ST_WRITE: begin
					if (fire) begin
						state_q <= kvt_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= kvt_pkg::ST_CLEAR;
				end
			endcase
		end
	end

	// Hold the accepted word
	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		if (accept) begin
			cmd_q <= kvt_pkg::cmd_t'(command);
			key_q <= key;
			val_q <= value_in[VALUE_BITS-1:0];
		end
	end

	// Track the matching slot and the lowest free slot as read words arrive
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (accept) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (pend_s1) begin
			if (match) begin
				hit_q <= 1'b1;
			end
			if (!rd_key.valid && !free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			if (match) begin
				hit_idx_q <= idx_s1;
				hit_val_q <= rd_val;
			end
			if (!rd_key.valid && !free_q) begin
				free_idx_q <= idx_s1;
			end
		end
	end

	// Decide the result and the write-back
	always_comb begin
		wr_ctl       = '0;
		wr_addr      = hit_idx_q;
		wr_key.valid = 1'b0;
		wr_key.key   = key_q;
		wr_val       = val_q;
		res.found    = hit_q;
		res.status   = kvt_pkg::STAT_DONE;
		res_val      = '0;
		if (state_q == kvt_pkg::ST_CLEAR) begin
			wr_addr       = addr_q;
			wr_ctl.key_we = 1'b1;
		end else begin
			unique case (cmd_q)
				kvt_pkg::CMD_INSERT: begin
					priority if (hit_q) begin
						res.status = kvt_pkg::STAT_PRESENT;
					end else if (free_q) begin
						wr_addr       = free_idx_q;
						wr_key.valid  = 1'b1;
						wr_ctl.key_we = fire;
						wr_ctl.val_we = fire;
					end else begin
						res.status = kvt_pkg::STAT_FULL;
					end
				end
				kvt_pkg::CMD_UPDATE: begin
					if (hit_q) begin
						wr_ctl.val_we = fire;
					end else begin
						res.status = kvt_pkg::STAT_ABSENT;
					end
				end
				kvt_pkg::CMD_LOOKUP: begin
					if (hit_q) begin
						res_val = hit_val_q;
					end else begin
						res.status = kvt_pkg::STAT_ABSENT;
					end
				end
				kvt_pkg::CMD_REMOVE: begin
					if (hit_q) begin
						wr_ctl.key_we = fire;
					end else begin
						res.status = kvt_pkg::STAT_ABSENT;
					end
				end
				default: begin
					res.status = kvt_pkg::STAT_ABSENT;
				end
			endcase
		end
	end

endmodule

FILE: tb/tb_key_value_table.sv
// Self-checking key/value table testbench: directed and random traffic against a predictor.
`timescale 1ns / 1ps

module tb_key_value_table;

	localparam int unsigned DEPTH       = 64;
	localparam int unsigned VALUE_BITS  = 64;
	localparam logic [63:0] VALUE_MASK  = {64{1'b1}} >> (64 - VALUE_BITS);
	localparam int          CYCLE_LIMIT = 1_200_000;
	localparam int          POOL_SIZE   = 128;

	// One table operation waiting to be sent
	typedef struct {
		kvt_pkg::cmd_t      command;
		logic signed [31:0] key;
		logic [63:0]        value;
		bit                 hold;
		bit                 calm;
	} table_op_t;

	// One predicted output word
	typedef struct {
		logic             found;
		logic [63:0]      value;
		kvt_pkg::status_t status;
	} table_reply_t;

	typedef enum {MIX_FILL, MIX_ANY, MIX_DRAIN} op_mix_t;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic [1:0]         command   = '0;
	logic signed [31:0] key       = '0;
	logic [63:0]        value_in  = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               found;
	logic [63:0]        value_out;
	logic [1:0]         status;

	key_value_table #(
		.DEPTH     (DEPTH),
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.key      (key),
		.value_in (value_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found    (found),
		.value_out(value_out),
		.status   (status)
	);

	// Predictor copy of the slot memories
	bit          slot_used [DEPTH];
	logic [31:0] slot_keys [DEPTH];
	logic [63:0] slot_vals [DEPTH];

	table_op_t    pending_ops[$];
	table_reply_t replies_due[$];

	int total_ops;
	int sent_cnt   = 0;
	int n_sent     = 0;
	int n_recv     = 0;
	int gap_left   = 0;
	int stall_left = 0;
	int errors     = 0;
	bit calm_now   = 1'b0;
	bit calm_block = 1'b0;

	logic [31:0] key_pool [POOL_SIZE];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Apply one operation to the predicted table and return its output word
	function automatic table_reply_t run_table_op(table_op_t op);
		table_reply_t r;
		int hit;
		int spare;
		hit   = -1;
		spare = -1;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (slot_used[i] && slot_keys[i] == op.key)
				hit = i;
			if (!slot_used[i])
				spare = i;
		end
		r.found  = (hit >= 0);
		r.value  = '0;
		r.status = kvt_pkg::STAT_DONE;
		case (op.command)
			kvt_pkg::CMD_INSERT: begin
				if (hit >= 0) begin
					r.status = kvt_pkg::STAT_PRESENT;
				end else if (spare < 0) begin
					r.status = kvt_pkg::STAT_FULL;
				end else begin
					slot_used[spare] = 1'b1;
					slot_keys[spare] = op.key;
					slot_vals[spare] = op.value & VALUE_MASK;
				end
			end
			kvt_pkg::CMD_UPDATE: begin
				if (hit >= 0)
					slot_vals[hit] = op.value & VALUE_MASK;
				else
					r.status = kvt_pkg::STAT_ABSENT;
			end
			kvt_pkg::CMD_LOOKUP: begin
				if (hit >= 0)
					r.value = slot_vals[hit] & VALUE_MASK;
				else
					r.status = kvt_pkg::STAT_ABSENT;
			end
			default: begin
				if (hit >= 0)
					slot_used[hit] = 1'b0;
				else
					r.status = kvt_pkg::STAT_ABSENT;
			end
		endcase
		return r;
	endfunction

	// Idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 12);
		else if (r < 97)
			return $urandom_range(13, 70);
		return $urandom_range(71, 150);
	endfunction

	task automatic queue_op(kvt_pkg::cmd_t c, logic [31:0] k, logic [63:0] v, bit hold);
		table_op_t op;
		op.command = c;
		op.key     = k;
		op.value   = v;
		op.hold    = hold;
		op.calm    = calm_block;
		pending_ops.push_back(op);
	endtask

	task automatic note_mismatch(string field, logic [63:0] want, logic [63:0] got);
		errors++;
		$error("%s: expected %0h, actual %0h", field, want, got);
	endtask

	// Driver: predict on each accepted word, then present the next one after its gap
	always @(posedge clk) begin : drive
		bit           next_valid;
		table_reply_t r;
		if (arst_n) begin
			next_valid = in_valid;
			if (in_valid && in_ready) begin
				r = run_table_op(pending_ops[0]);
				replies_due.push_back(r);
				calm_now <= pending_ops[0].calm;
				gap_left = pending_ops[0].calm ? 0 : pick_gap();
				pending_ops.pop_front();
				sent_cnt++;
				n_sent <= sent_cnt;
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_ops.size() > 0 &&
				             (!pending_ops[0].hold || sent_cnt == n_recv)) begin
					next_valid = 1'b1;
					command  <= pending_ops[0].command;
					key      <= pending_ops[0].key;
					value_in <= pending_ops[0].value;
				end
			end
			in_valid <= next_valid;
		end
	end

	// Monitor: check each accepted output word against the oldest prediction
	always @(posedge clk) begin : sink
		table_reply_t want;
		bit           rdy;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					errors++;
					$error("output word with no prediction waiting");
				end else begin
					want = replies_due.pop_front();
					if (found !== want.found)
						note_mismatch("found", 64'(want.found), 64'(found));
					if (value_out !== want.value)
						note_mismatch("value_out", want.value, value_out);
					if (status !== want.status)
						note_mismatch("status", 64'(want.status), 64'(status));
				end
				n_recv <= n_recv + 1;
			end
			// Stall the output side at random, except in calm stretches
			if (calm_now) begin
				stall_left = 0;
				rdy = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else if ($urandom_range(0, 99) < 25) begin
				stall_left = pick_gap();
				rdy = (stall_left == 0);
			end else begin
				rdy = 1'b1;
			end
			out_ready <= rdy;
		end
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		op_mix_t       mix;
		int            pool_n;
		int            r;
		kvt_pkg::cmd_t c;
		logic [31:0]   k;
		for (int i = 0; i < DEPTH; i++)
			slot_used[i] = 1'b0;

		// Directed: empty-table misses, key extremes, duplicates, reuse of a freed slot
		queue_op(kvt_pkg::CMD_LOOKUP, 32'h0000_0000, 64'hDEAD_BEEF_0000_0001, 1'b0);
		queue_op(kvt_pkg::CMD_UPDATE, 32'h7FFF_FFFF, 64'h1, 1'b0);
		queue_op(kvt_pkg::CMD_REMOVE, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		queue_op(kvt_pkg::CMD_INSERT, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		queue_op(kvt_pkg::CMD_INSERT, 32'h7FFF_FFFF, 64'h0, 1'b0);
		queue_op(kvt_pkg::CMD_INSERT, 32'h0000_0000, 64'h8000_0000_0000_0001, 1'b0);
		queue_op(kvt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 64'h5555_5555_5555_5555, 1'b0);
		queue_op(kvt_pkg::CMD_INSERT, 32'h8000_0000, 64'h1234, 1'b0);
		queue_op(kvt_pkg::CMD_LOOKUP, 32'h8000_0000, 64'h0, 1'b1);
		queue_op(kvt_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		queue_op(kvt_pkg::CMD_LOOKUP, 32'h8000_0001, 64'h0, 1'b0);
		queue_op(kvt_pkg::CMD_UPDATE, 32'h0000_0000, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		queue_op(kvt_pkg::CMD_LOOKUP, 32'h0000_0000, 64'h0, 1'b0);
		queue_op(kvt_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 64'h0, 1'b0);
		queue_op(kvt_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 64'h0, 1'b0);
		queue_op(kvt_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 64'h0, 1'b0);
		queue_op(kvt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF, 1'b0);
		queue_op(kvt_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 64'h0, 1'b0);
		queue_op(kvt_pkg::CMD_UPDATE, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		queue_op(kvt_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, 64'h0, 1'b0);
		queue_op(kvt_pkg::CMD_REMOVE, 32'h8000_0000, 64'h0, 1'b0);
		queue_op(kvt_pkg::CMD_LOOKUP, 32'h8000_0000, 64'h0, 1'b0);

		// Random: 16 blocks of 50 words, keys mostly from a pool; fill, then drain, then mixed
		for (int blk = 0; blk < 16; blk++) begin
			if (blk % 4 == 0) begin
				for (int i = 0; i < POOL_SIZE; i++)
					key_pool[i] = $urandom;
				if ($urandom_range(0, 1)) begin
					key_pool[0] = 32'h8000_0000;
					key_pool[1] = 32'h7FFF_FFFF;
					key_pool[2] = 32'h0000_0000;
					key_pool[3] = 32'hFFFF_FFFF;
				end
			end
			if (blk < 3) begin
				mix    = MIX_FILL;
				pool_n = 120;
			end else if (blk == 3) begin
				mix    = MIX_DRAIN;
				pool_n = 120;
			end else begin
				mix    = op_mix_t'($urandom_range(0, 2));
				pool_n = $urandom_range(4, 100);
			end
			calm_block = (blk % 5 == 2);
			for (int i = 0; i < 50; i++) begin
				r = $urandom_range(0, 99);
				case (mix)
					MIX_FILL: begin
						c = kvt_pkg::cmd_t'((r < 75) ? kvt_pkg::CMD_INSERT :
						    (r < 85) ? kvt_pkg::CMD_LOOKUP :
						    (r < 95) ? kvt_pkg::CMD_UPDATE : kvt_pkg::CMD_REMOVE);
					end
					MIX_DRAIN: begin
						c = kvt_pkg::cmd_t'((r < 50) ? kvt_pkg::CMD_REMOVE :
						    (r < 80) ? kvt_pkg::CMD_LOOKUP :
						    (r < 90) ? kvt_pkg::CMD_UPDATE : kvt_pkg::CMD_INSERT);
					end
					default: c = kvt_pkg::cmd_t'($urandom_range(0, 3));
				endcase
				k = ($urandom_range(0, 9) == 0) ? $urandom :
				    key_pool[$urandom_range(0, pool_n - 1)];
				queue_op(c, k, {$urandom, $urandom}, i == 0 && blk % 4 == 1);
			end
		end
		total_ops = pending_ops.size();

		// Hold reset, then let the handshakes run
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (!(n_sent == total_ops && n_recv == n_sent));
		repeat (DEPTH + 10) @(posedge clk);

		if (replies_due.size() != 0) begin
			errors++;
			$error("%0d predicted words never arrived", replies_due.size());
		end
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
